[hdl/vmis_pkg.sv]
`default_nettype none
package vmis_pkg;

  localparam int unsigned POS_BITS_DFLT = 32;
  localparam int unsigned WIN_LEN       = 7;
  localparam int unsigned OUTQ_DEPTH    = 4;
  localparam int unsigned OUTQ_AW       = $clog2(OUTQ_DEPTH);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] BOOK_MAX   = 8'd255;

  typedef logic [WIN_LEN-1:0][7:0] window_t;
  localparam window_t WIN_SPACES = {WIN_LEN{CHAR_SPACE}};

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CHAPTER = 2'd1,
    ST_VERSE   = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]         book_number;
    logic [9:0]         chapter_number;
    logic [9:0]         verse_number;
    logic [31:0]        text_offset;
    logic signed [15:0] text_size;
    logic               starts_chapter;
    logic               starts_book;
    status_t            status;
    logic               last_of_run;
  } rec_t;

  // records handed from the scan stage to the output queue
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  typedef struct packed {
    logic [7:0] book;
    logic [9:0] cur_ch;
    logic [9:0] cur_vs;
    status_t    status;
  } emit_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // atoi over three characters, non-digits behave as spaces
  function automatic logic [9:0] parse_group(logic [2:0][7:0] g);
    logic [9:0] v;
    logic       got;
    logic       stop;
    v    = '0;
    got  = 1'b0;
    stop = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!stop) begin
        if (is_digit(g[i])) begin
          v   = (v << 3) + (v << 1) + 10'(g[i] - CHAR_ZERO);
          got = 1'b1;
        end else if (got) begin
          stop = 1'b1;
        end
      end
    end
    return v;
  endfunction

  function automatic logic [1:0] digit_count(logic [9:0] v);
    if (v >= 10'd100) return 2'd3;
    if (v >= 10'd10)  return 2'd2;
    return 2'd1;
  endfunction

  function automatic emit_t emit_step(logic [7:0] book, logic [9:0] cch, logic [9:0] cvs,
                                      logic [9:0] ch, logic [9:0] vs);
    emit_t e;
    e.book   = book;
    e.cur_ch = cch;
    e.cur_vs = cvs;
    if (vs == 10'd1) begin
      if (ch == 10'd1) begin
        if (book != BOOK_MAX) e.book = book + 8'd1;
        e.cur_ch = '0;
      end
      e.cur_vs = 10'd1;
      e.cur_ch = e.cur_ch + 10'd1;
    end else begin
      e.cur_vs = cvs + 10'd1;
    end
    if (ch != e.cur_ch)      e.status = ST_CHAPTER;
    else if (vs != e.cur_vs) e.status = ST_VERSE;
    else                     e.status = ST_OK;
    return e;
  endfunction

  function automatic rec_t make_rec(emit_t e, logic [9:0] ch, logic [9:0] vs,
                                    logic [31:0] off, logic [15:0] size);
    rec_t r;
    r.book_number    = e.book;
    r.chapter_number = ch;
    r.verse_number   = vs;
    r.text_offset    = off;
    r.text_size      = size;
    r.starts_chapter = (vs == 10'd1);
    r.starts_book    = (vs == 10'd1) && (ch == 10'd1);
    r.status         = e.status;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/vmis_ifs.sv]
`default_nettype none
interface vmis_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface vmis_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         book_number;
  logic [9:0]         chapter_number;
  logic [9:0]         verse_number;
  logic [31:0]        text_offset;
  logic signed [15:0] text_size;
  logic               starts_chapter;
  logic               starts_book;
  logic [1:0]         status;
  logic               last_of_run;

  modport source (output valid, output book_number, output chapter_number,
                  output verse_number, output text_offset, output text_size,
                  output starts_chapter, output starts_book, output status,
                  output last_of_run, input ready);
  modport sink   (input valid, input book_number, input chapter_number,
                  input verse_number, input text_offset, input text_size,
                  input starts_chapter, input starts_book, input status,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

[hdl/verse_marker_index_scanner_top.sv]
// an input byte is registered, then scanned; a record it ends enters the queue
// throughput: one byte per cycle while the output queue has room
// an end-of-text byte that closes two markers puts two records into the queue,
// drained at one record per cycle when ready is high, via a four-entry queue
// reset: synchronous, active low; clears window, counters and queue at once
`default_nettype none
module verse_marker_index_scanner_top #(
  parameter int unsigned POSITION_BITS = vmis_pkg::POS_BITS_DFLT
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  vmis_in_if.sink     in_chan,
  vmis_out_if.source  out_chan
);

  vmis_pkg::push_t push;
  vmis_pkg::rec_t  head;
  logic            room;

  vmis_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .room    (room),
    .push    (push)
  );

  vmis_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (out_chan.valid),
    .head_ready (out_chan.ready),
    .head       (head)
  );

  assign out_chan.book_number    = head.book_number;
  assign out_chan.chapter_number = head.chapter_number;
  assign out_chan.verse_number   = head.verse_number;
  assign out_chan.text_offset    = head.text_offset;
  assign out_chan.text_size      = head.text_size;
  assign out_chan.starts_chapter = head.starts_chapter;
  assign out_chan.starts_book    = head.starts_book;
  assign out_chan.status         = head.status;
  assign out_chan.last_of_run    = head.last_of_run;

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status != 2'(vmis_pkg::ST_OK)) |-> out_chan.last_of_run)
    else $error("sequence error record not last of run");

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.status != 2'(vmis_pkg::ST_OK))
    |=> !out_chan.valid)
    else $error("record after sequence error");

  a_book_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.starts_book) |-> out_chan.starts_chapter)
    else $error("new book without new chapter");

endmodule
`default_nettype wire

[hdl/vmis_core.sv]
`default_nettype none
module vmis_core #(
  parameter int unsigned POSITION_BITS = vmis_pkg::POS_BITS_DFLT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  vmis_in_if.sink          in_chan,
  input  wire logic        room,
  output vmis_pkg::push_t  push
);

  localparam int unsigned PB = POSITION_BITS;

  logic                    in_valid_r;
  logic [7:0]              byte_r;
  logic                    eot_r;

  vmis_pkg::window_t       win_r, win_nxt, wn;
  logic [PB-1:0]           bs_r, bs_nxt, seen, off_new;
  logic                    pend_valid_r, pend_valid_nxt;
  logic [PB-1:0]           pend_off_r, pend_off_nxt;
  logic [9:0]              pend_ch_r, pend_ch_nxt, pend_vs_r, pend_vs_nxt;
  logic [7:0]              book_r, book_nxt;
  logic [9:0]              cur_ch_r, cur_ch_nxt, cur_vs_r, cur_vs_nxt;
  logic                    halted_r, halted_nxt;

  logic                    fire, match, has_a, err_a;
  logic [9:0]              ch_new, vs_new;
  logic [1:0]              dc_ch, dc_vs;
  logic [15:0]             size_a, size_b;
  vmis_pkg::emit_t         e_a, e_b;
  vmis_pkg::rec_t          rec_a, rec_b;

  assign in_chan.ready = !in_valid_r || room;
  assign fire          = in_valid_r && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      byte_r <= in_chan.data_byte;
      eot_r  <= in_chan.end_of_text;
    end
  end

  // window shift and marker decode
  assign wn      = {byte_r, win_r[vmis_pkg::WIN_LEN-1:1]};
  assign ch_new  = vmis_pkg::parse_group(wn[2:0]);
  assign vs_new  = vmis_pkg::parse_group(wn[6:4]);
  assign match   = (wn[3] == vmis_pkg::CHAR_COLON) && (ch_new != '0) && (vs_new != '0);
  assign dc_ch   = vmis_pkg::digit_count(ch_new);
  assign dc_vs   = vmis_pkg::digit_count(vs_new);
  assign seen    = bs_r + PB'(1);
  assign off_new = bs_r + PB'(dc_vs - 2'd1);

  assign has_a  = match && pend_valid_r;
  assign e_a    = vmis_pkg::emit_step(book_r, cur_ch_r, cur_vs_r, pend_ch_r, pend_vs_r);
  assign err_a  = has_a && (e_a.status != vmis_pkg::ST_OK);
  assign size_a = 16'(bs_r) - 16'(pend_off_r) - 16'(dc_ch) - 16'd4;
  assign rec_a  = vmis_pkg::make_rec(e_a, pend_ch_r, pend_vs_r, 32'(pend_off_r), size_a);
  assign size_b = match ? (16'd2 - 16'(dc_vs)) : (16'(seen) - 16'(pend_off_r));

  always_comb begin
    win_nxt        = win_r;
    bs_nxt         = bs_r;
    pend_valid_nxt = pend_valid_r;
    pend_off_nxt   = pend_off_r;
    pend_ch_nxt    = pend_ch_r;
    pend_vs_nxt    = pend_vs_r;
    book_nxt       = book_r;
    cur_ch_nxt     = cur_ch_r;
    cur_vs_nxt     = cur_vs_r;
    halted_nxt     = halted_r;
    e_b            = '0;
    rec_b          = '0;
    push           = '0;
    if (fire && !halted_r) begin
      win_nxt = wn;
      bs_nxt  = seen;
      if (err_a) begin
        halted_nxt             = 1'b1;
        push.cnt               = 2'd1;
        push.rec0              = rec_a;
        push.rec0.last_of_run  = 1'b1;
      end else begin
        if (has_a) begin
          book_nxt   = e_a.book;
          cur_ch_nxt = e_a.cur_ch;
          cur_vs_nxt = e_a.cur_vs;
          push.cnt   = 2'd1;
          push.rec0  = rec_a;
        end
        if (match) begin
          pend_valid_nxt = 1'b1;
          pend_off_nxt   = off_new;
          pend_ch_nxt    = ch_new;
          pend_vs_nxt    = vs_new;
          win_nxt        = vmis_pkg::WIN_SPACES;
        end
        if (eot_r) begin
          if (pend_valid_nxt) begin
            e_b   = vmis_pkg::emit_step(book_nxt, cur_ch_nxt, cur_vs_nxt,
                                        pend_ch_nxt, pend_vs_nxt);
            rec_b = vmis_pkg::make_rec(e_b, pend_ch_nxt, pend_vs_nxt,
                                       32'(pend_off_nxt), size_b);
            rec_b.last_of_run = 1'b1;
            if (has_a) begin
              push.cnt  = 2'd2;
              push.rec1 = rec_b;
            end else begin
              push.cnt  = 2'd1;
              push.rec0 = rec_b;
            end
            if (e_b.status != vmis_pkg::ST_OK) halted_nxt = 1'b1;
          end else if (has_a) begin
            push.rec0.last_of_run = 1'b1;
          end
          win_nxt        = vmis_pkg::WIN_SPACES;
          bs_nxt         = '0;
          pend_valid_nxt = 1'b0;
          pend_off_nxt   = '0;
          pend_ch_nxt    = '0;
          pend_vs_nxt    = '0;
          book_nxt       = '0;
          cur_ch_nxt     = '0;
          cur_vs_nxt     = '0;
        end else if (has_a) begin
          push.rec0.last_of_run = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= vmis_pkg::WIN_SPACES;
      bs_r         <= '0;
      pend_valid_r <= 1'b0;
      pend_off_r   <= '0;
      pend_ch_r    <= '0;
      pend_vs_r    <= '0;
      book_r       <= '0;
      cur_ch_r     <= '0;
      cur_vs_r     <= '0;
      halted_r     <= 1'b0;
    end else begin
      win_r        <= win_nxt;
      bs_r         <= bs_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_off_r   <= pend_off_nxt;
      pend_ch_r    <= pend_ch_nxt;
      pend_vs_r    <= pend_vs_nxt;
      book_r       <= book_nxt;
      cur_ch_r     <= cur_ch_nxt;
      cur_vs_r     <= cur_vs_nxt;
      halted_r     <= halted_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/vmis_outq.sv]
`default_nettype none
module vmis_outq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire vmis_pkg::push_t  push,
  output logic                  room,
  output logic                  head_valid,
  input  wire logic             head_ready,
  output vmis_pkg::rec_t        head
);

  localparam int unsigned AW = vmis_pkg::OUTQ_AW;
  localparam int unsigned CW = AW + 1;

  vmis_pkg::rec_t    mem_r [vmis_pkg::OUTQ_DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pop;

  assign room       = cnt_r <= CW'(vmis_pkg::OUTQ_DEPTH - 2);
  assign head_valid = cnt_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid && head_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    cnt_nxt    = cnt_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.rec0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_r + AW'(1)] <= push.rec1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire
